[rtl/dhcp_option_tlv_parser_macros.svh]
// Assertion macros shared by the DHCP option parser modules.
`ifndef DHCP_OPTION_TLV_PARSER_MACROS_SVH
`define DHCP_OPTION_TLV_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DOTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DOTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dotp_pkg.sv]
// Shared types and constants of the DHCP option parser.
`timescale 1ns / 1ps

package dotp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] SEARCH_KEY_RESET = 8'd54;

  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam logic [7:0] OPT_MASK = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS = 8'd6;
  localparam logic [7:0] OPT_NTP = 8'd42;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END = 8'hff;

  // One classified byte as it travels from the front through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_pad;
    logic       is_end;
  } word_t;

endpackage

[rtl/dotp_front.sv]
// Front part: accepts input words and classifies each byte.
`timescale 1ns / 1ps

module dotp_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            q_full,
  output logic            push,
  output dotp_pkg::word_t word
);

  // Stall only depends on queue room, never on valid.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    word.data   = data_byte;
    word.last   = last_byte;
    word.is_pad = (data_byte == dotp_pkg::OPT_PAD);
    word.is_end = (data_byte == dotp_pkg::OPT_END);
  end

endmodule

[rtl/dotp_queue.sv]
// Short word queue between the front and back parts.
`timescale 1ns / 1ps
`include "dhcp_option_tlv_parser_macros.svh"

module dotp_queue #(
  parameter int unsigned Depth = dotp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dotp_pkg::word_t wdata,
  input  logic            pop,
  output logic            valid,
  output logic            full,
  output dotp_pkg::word_t rdata
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dotp_pkg::word_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign valid = (count != '0);
  assign full  = (count == CntFull);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DOTP_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue written while full")
  `DOTP_ASSERT_NOW(a_no_underflow, pop, valid, "queue read while empty")
  `DOTP_ASSERT_NOW(a_count_range, 1'b1, count <= CntFull, "queue count beyond depth")

endmodule

[rtl/dotp_back.sv]
// Back part: walks the option records and holds the result register.
`timescale 1ns / 1ps
`include "dhcp_option_tlv_parser_macros.svh"

module dotp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  logic            q_valid,
  input  dotp_pkg::word_t q_word,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      message_type,
  output logic [31:0]     subnet_mask,
  output logic [31:0]     router_addr,
  output logic [31:0]     dns_addr,
  output logic [31:0]     ntp_addr,
  output logic [31:0]     key_value,
  output logic            key_found,
  output logic            truncated
);

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VAL,
    PH_DONE
  } phase_t;

  phase_t      phase;
  logic [7:0]  search_key;
  logic [7:0]  cur_code;
  logic [7:0]  bytes_left;
  logic [2:0]  value_index;
  logic [31:0] value_shift;
  logic [7:0]  type_store;
  logic [31:0] mask_store;
  logic [31:0] router_store;
  logic [31:0] dns_store;
  logic [31:0] ntp_store;
  logic [31:0] key_store;
  logic        key_seen;

  phase_t      phase_next;
  logic [7:0]  cur_code_next;
  logic [7:0]  bytes_left_next;
  logic [2:0]  value_index_next;
  logic [31:0] value_shift_next;
  logic        step_commit;
  logic        commit;
  logic [7:0]  type_next;
  logic [31:0] mask_next;
  logic [31:0] router_next;
  logic [31:0] dns_next;
  logic [31:0] ntp_next;
  logic [31:0] key_store_next;
  logic        key_seen_next;
  logic        trunc_next;

  // A final word may only leave the queue when the result register is free.
  assign pop = q_valid && (!q_word.last || !out_valid || !out_stall);

  always_comb begin
    phase_next       = phase;
    cur_code_next    = cur_code;
    bytes_left_next  = bytes_left;
    value_index_next = value_index;
    value_shift_next = value_shift;
    step_commit      = 1'b0;
    case (phase)
      PH_CODE: begin
        if (q_word.is_end) begin
          phase_next = PH_DONE;
        end else if (!q_word.is_pad) begin
          cur_code_next = q_word.data;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_left_next  = q_word.data;
        value_index_next = '0;
        value_shift_next = '0;
        if (q_word.data == 8'd0) begin
          step_commit = 1'b1;
          phase_next  = PH_CODE;
        end else begin
          phase_next = PH_VAL;
        end
      end
      PH_VAL: begin
        if (!value_index[2]) begin
          case (value_index[1:0])
            2'd0: value_shift_next[31:24] = q_word.data;
            2'd1: value_shift_next[23:16] = q_word.data;
            2'd2: value_shift_next[15:8]  = q_word.data;
            default: value_shift_next[7:0] = q_word.data;
          endcase
          value_index_next = value_index + 3'd1;
        end
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          step_commit = 1'b1;
          phase_next  = PH_CODE;
        end
      end
      default: begin
      end
    endcase
  end

  // A record cut short inside its value by the final word is committed with what it has.
  always_comb begin
    trunc_next = q_word.last && (phase_next == PH_LEN || phase_next == PH_VAL);
    commit     = step_commit || (q_word.last && phase_next == PH_VAL);

    type_next      = type_store;
    mask_next      = mask_store;
    router_next    = router_store;
    dns_next       = dns_store;
    ntp_next       = ntp_store;
    key_store_next = key_store;
    key_seen_next  = key_seen;
    if (commit) begin
      case (cur_code_next)
        dotp_pkg::OPT_MSG_TYPE: type_next   = value_shift_next[31:24];
        dotp_pkg::OPT_MASK:     mask_next   = value_shift_next;
        dotp_pkg::OPT_ROUTER:   router_next = value_shift_next;
        dotp_pkg::OPT_DNS:      dns_next    = value_shift_next;
        dotp_pkg::OPT_NTP:      ntp_next    = value_shift_next;
        default: begin
        end
      endcase
      if (cur_code_next == search_key && !key_seen) begin
        key_store_next = value_shift_next;
        key_seen_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_key   <= dotp_pkg::SEARCH_KEY_RESET;
      phase        <= PH_CODE;
      cur_code     <= '0;
      bytes_left   <= '0;
      value_index  <= '0;
      value_shift  <= '0;
      type_store   <= '0;
      mask_store   <= '0;
      router_store <= '0;
      dns_store    <= '0;
      ntp_store    <= '0;
      key_store    <= '0;
      key_seen     <= 1'b0;
      out_valid    <= 1'b0;
      message_type <= '0;
      subnet_mask  <= '0;
      router_addr  <= '0;
      dns_addr     <= '0;
      ntp_addr     <= '0;
      key_value    <= '0;
      key_found    <= 1'b0;
      truncated    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        search_key <= cfg_wr_data;
      end
      out_valid <= (pop && q_word.last) || (out_valid && out_stall);
      if (pop) begin
        if (q_word.last) begin
          message_type <= type_next;
          subnet_mask  <= mask_next;
          router_addr  <= router_next;
          dns_addr     <= dns_next;
          ntp_addr     <= ntp_next;
          key_value    <= key_store_next;
          key_found    <= key_seen_next;
          truncated    <= trunc_next;
          phase        <= PH_CODE;
          cur_code     <= '0;
          bytes_left   <= '0;
          value_index  <= '0;
          value_shift  <= '0;
          type_store   <= '0;
          mask_store   <= '0;
          router_store <= '0;
          dns_store    <= '0;
          ntp_store    <= '0;
          key_store    <= '0;
          key_seen     <= 1'b0;
        end else begin
          phase        <= phase_next;
          cur_code     <= cur_code_next;
          bytes_left   <= bytes_left_next;
          value_index  <= value_index_next;
          value_shift  <= value_shift_next;
          type_store   <= type_next;
          mask_store   <= mask_next;
          router_store <= router_next;
          dns_store    <= dns_next;
          ntp_store    <= ntp_next;
          key_store    <= key_store_next;
          key_seen     <= key_seen_next;
        end
      end
    end
  end

  `DOTP_ASSERT_NEXT(a_last_loads_result, pop && q_word.last, out_valid, "final word lost")
  `DOTP_ASSERT_NOW(a_val_has_bytes, phase == PH_VAL, bytes_left != 8'd0, "value phase empty")
  `DOTP_ASSERT_NOW(a_index_range, 1'b1, value_index <= 3'd4, "value index past four")
  `DOTP_ASSERT_NOW(a_key_zero_unseen, !key_seen, key_store == 32'd0, "key value without key")

endmodule

[rtl/dhcp_option_tlv_parser.sv]
// Top level of the DHCP options parser: front, word queue and back part.
// Throughput: one word per cycle while the queue has room; the back part retires one
// queued word each cycle, but a final word waits while an earlier result is stalled.
// An accepted final word passes through the queue into the back part's result register.
// Reset (rst, synchronous, active high) empties the queue, clears all captured
// options and the result register, and sets search_key to 54.
`timescale 1ns / 1ps

module dhcp_option_tlv_parser #(
  parameter int unsigned QueueDepth = dotp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  message_type,
  output logic [31:0] subnet_mask,
  output logic [31:0] router_addr,
  output logic [31:0] dns_addr,
  output logic [31:0] ntp_addr,
  output logic [31:0] key_value,
  output logic        key_found,
  output logic        truncated
);

  // The front tags each incoming word as pad or end so the back part only
  // has to track where it is inside the current code, length, value record.
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  dotp_pkg::word_t front_word;
  dotp_pkg::word_t q_word;

  dotp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .word      (front_word)
  );

  // The queue absorbs words while a finished result waits on the output;
  // the input side only stalls once it is full.
  dotp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_word),
    .pop   (pop),
    .valid (q_valid),
    .full  (q_full),
    .rdata (q_word)
  );

  // The back part holds the record walk, the captured option values and the
  // result register; a final word waits in the queue only while an earlier
  // result is still stalled.
  dotp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .message_type (message_type),
    .subnet_mask  (subnet_mask),
    .router_addr  (router_addr),
    .dns_addr     (dns_addr),
    .ntp_addr     (ntp_addr),
    .key_value    (key_value),
    .key_found    (key_found),
    .truncated    (truncated)
  );

endmodule

[tb/dhcp_option_tlv_parser_test.sv]
// Self-checking testbench for the DHCP options TLV parser.
`timescale 1ns / 1ps

module dhcp_option_tlv_parser_test;

  // A run with no handshake on either side for this many cycles is a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  // Minimum words per search key setting in the random part; messages are sent whole.
  localparam int WORDS_PER_KEY = 65;

  // Everything the parser reports for one message.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] mask;
    logic [31:0] router;
    logic [31:0] dns;
    logic [31:0] ntp;
    logic [31:0] key;
    logic        found;
    logic        trunc;
  } dhcp_summary_t;

  // One row of the directed table. When typed is set, want holds the
  // summary written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [7:0]    data;
    logic          last;
    logic          typed;
    dhcp_summary_t want;
  } table_row_t;

  // Where the predictor stands inside the code, length, value walk.
  typedef enum logic [1:0] {
    AT_CODE,
    AT_LEN,
    AT_VALUE,
    PAST_END
  } walk_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  message_type;
  logic [31:0] subnet_mask;
  logic [31:0] router_addr;
  logic [31:0] dns_addr;
  logic [31:0] ntp_addr;
  logic [31:0] key_value;
  logic        key_found;
  logic        truncated;

  dhcp_option_tlv_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .message_type(message_type),
    .subnet_mask (subnet_mask),
    .router_addr (router_addr),
    .dns_addr    (dns_addr),
    .ntp_addr    (ntp_addr),
    .key_value   (key_value),
    .key_found   (key_found),
    .truncated   (truncated)
  );

  always #2 clk = ~clk;

  // Predictor state: a private copy of the parser's walk and captures.
  walk_phase_t walk_phase;
  logic [7:0]  rec_code;
  logic [7:0]  rec_left;
  logic [2:0]  rec_index;
  logic [31:0] rec_value;
  logic [7:0]  seen_type;
  logic [31:0] seen_mask;
  logic [31:0] seen_router;
  logic [31:0] seen_dns;
  logic [31:0] seen_ntp;
  logic [31:0] key_capture;
  logic        key_hit;
  logic [7:0]  search_key_copy;

  dhcp_summary_t expected_summaries[$];
  table_row_t    table_rows[$];
  logic [7:0]    msg_bytes[$];
  logic [7:0]    key_plan[6];
  dhcp_summary_t oldest;
  int            failures = 0;
  int            quiet_cycles = 0;
  int            words_sent;
  // While calm is set neither side inserts bubbles or stalls.
  bit            calm = 1'b0;

  function automatic dhcp_summary_t make_summary(
    input logic [7:0] msg_type, input logic [31:0] mask, input logic [31:0] router,
    input logic [31:0] dns, input logic [31:0] ntp, input logic [31:0] key,
    input logic found, input logic trunc);
    dhcp_summary_t s;
    s.msg_type = msg_type;
    s.mask = mask;
    s.router = router;
    s.dns = dns;
    s.ntp = ntp;
    s.key = key;
    s.found = found;
    s.trunc = trunc;
    return s;
  endfunction

  // Return the walk and every capture to the state of a fresh message.
  // The search key is a register and survives.
  function automatic void clear_walk();
    walk_phase = AT_CODE;
    rec_code = 8'd0;
    rec_left = 8'd0;
    rec_index = 3'd0;
    rec_value = 32'd0;
    seen_type = 8'd0;
    seen_mask = 32'd0;
    seen_router = 32'd0;
    seen_dns = 32'd0;
    seen_ntp = 32'd0;
    key_capture = 32'd0;
    key_hit = 1'b0;
  endfunction

  // A finished record lands in the store of its option, and the first
  // record carrying the search key is latched on top of that.
  function automatic void commit_record();
    case (rec_code)
      dotp_pkg::OPT_MSG_TYPE: seen_type = rec_value[31:24];
      dotp_pkg::OPT_MASK:     seen_mask = rec_value;
      dotp_pkg::OPT_ROUTER:   seen_router = rec_value;
      dotp_pkg::OPT_DNS:      seen_dns = rec_value;
      dotp_pkg::OPT_NTP:      seen_ntp = rec_value;
      default: ;
    endcase
    if (rec_code == search_key_copy && !key_hit) begin
      key_capture = rec_value;
      key_hit = 1'b1;
    end
  endfunction

  // Advance the walk by one word. Returns 1 and the summary when the word
  // closes the message.
  function automatic bit walk_option_byte(input logic [7:0] b, input logic lst,
                                          output dhcp_summary_t res);
    logic cut_short;
    res = '0;
    case (walk_phase)
      AT_CODE: begin
        // Pad is a lone word; end parks the walk until the message closes.
        if (b == dotp_pkg::OPT_END) begin
          walk_phase = PAST_END;
        end else if (b != dotp_pkg::OPT_PAD) begin
          rec_code = b;
          walk_phase = AT_LEN;
        end
      end
      AT_LEN: begin
        rec_left = b;
        rec_index = 3'd0;
        rec_value = 32'd0;
        if (b == 8'd0) begin
          commit_record();
          walk_phase = AT_CODE;
        end else begin
          walk_phase = AT_VALUE;
        end
      end
      AT_VALUE: begin
        // Only the first four value words count; they fill from the top.
        if (rec_index < 3'd4) begin
          rec_value[31 - 8 * int'(rec_index) -: 8] = b;
          rec_index = rec_index + 3'd1;
        end
        rec_left = rec_left - 8'd1;
        if (rec_left == 8'd0) begin
          commit_record();
          walk_phase = AT_CODE;
        end
      end
      default: ;
    endcase
    if (!lst) return 1'b0;
    // A message that stops inside a record is flagged; a partial value
    // still counts, zero-filled.
    cut_short = (walk_phase == AT_LEN || walk_phase == AT_VALUE);
    if (walk_phase == AT_VALUE) commit_record();
    res = make_summary(seen_type, seen_mask, seen_router, seen_dns, seen_ntp,
                       key_capture, key_hit, cut_short);
    clear_walk();
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic lst,
                                  input logic typed, input dhcp_summary_t want);
    table_row_t r;
    r.data = b;
    r.last = lst;
    r.typed = typed;
    r.want = want;
    table_rows.push_back(r);
  endfunction

  // Build one random message into msg_bytes. Most are well-formed record
  // sequences; some stop short, some close with an end code and up to three
  // junk words after it, and a few are plain noise.
  function automatic void build_message(input logic [7:0] key);
    int         style;
    int         len;
    int         cut;
    int         pick;
    logic [7:0] code;
    msg_bytes.delete();
    style = $urandom_range(99);
    if (style < 10) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(9))
        0: code = dotp_pkg::OPT_PAD;
        1: code = dotp_pkg::OPT_MASK;
        2: code = dotp_pkg::OPT_ROUTER;
        3: code = dotp_pkg::OPT_DNS;
        4: code = dotp_pkg::OPT_NTP;
        5: code = dotp_pkg::OPT_MSG_TYPE;
        6, 7: code = key;
        default: code = 8'($urandom_range(1, 254));
      endcase
      msg_bytes.push_back(code);
      if (code != dotp_pkg::OPT_PAD) begin
        // Mostly short values, a few past four words, and now and then a
        // record whose length may reach the top of the length field.
        pick = $urandom_range(99);
        if (pick < 8) len = 0;
        else if (pick < 85) len = $urandom_range(1, 6);
        else if (pick < 97) len = $urandom_range(7, 16);
        else len = $urandom_range(17, 255);
        msg_bytes.push_back(8'(len));
        repeat (len) msg_bytes.push_back(8'($urandom));
      end
    end
    if (style < 60) begin
      msg_bytes.push_back(dotp_pkg::OPT_END);
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
    end else if (style < 80 && msg_bytes.size() > 1) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
    if (msg_bytes.size() == 0) msg_bytes.push_back(dotp_pkg::OPT_END);
  endfunction

  // Offer one word, with random bubbles ahead of it, and hold it until the
  // parser takes it. The expectation is queued at the accepting edge, which
  // is well ahead of the registered result.
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input dhcp_summary_t want);
    dhcp_summary_t predicted;
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (walk_option_byte(b, lst, predicted)) begin
      expected_summaries.push_back(typed ? want : predicted);
    end
  endtask

  // The key register may only change while the parser is idle: every
  // message has been reported and the two-stage pipeline has drained.
  task automatic set_search_key(input logic [7:0] k);
    in_valid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    search_key_copy = k;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  // Result side: compare every accepted summary with the oldest one
  // predicted, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_summaries.size() == 0) begin
        $error("result with no message pending");
        failures++;
      end else begin
        oldest = expected_summaries.pop_front();
        check_field("message_type", 32'(oldest.msg_type), 32'(message_type));
        check_field("subnet_mask", oldest.mask, subnet_mask);
        check_field("router_addr", oldest.router, router_addr);
        check_field("dns_addr", oldest.dns, dns_addr);
        check_field("ntp_addr", oldest.ntp, ntp_addr);
        check_field("key_value", oldest.key, key_value);
        check_field("key_found", 32'(oldest.found), 32'(key_found));
        check_field("truncated", 32'(oldest.trunc), 32'(truncated));
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  // Watchdog: a long run of cycles with no handshake on either side means
  // the parser has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    search_key_copy = dotp_pkg::SEARCH_KEY_RESET;
    clear_walk();

    // Directed messages, run under the key left by reset (server identifier).
    // A lone end code right after reset reports an all-zero summary.
    add_row(dotp_pkg::OPT_END, 1'b1, 1'b1,
            make_summary(8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    // Pad, then message type 5, then the server identifier found by key.
    add_row(dotp_pkg::OPT_PAD, 1'b0, 1'b0, '0);
    add_row(dotp_pkg::OPT_MSG_TYPE, 1'b0, 1'b0, '0);
    add_row(8'd1, 1'b0, 1'b0, '0);
    add_row(8'd5, 1'b0, 1'b0, '0);
    add_row(dotp_pkg::SEARCH_KEY_RESET, 1'b0, 1'b0, '0);
    add_row(8'd4, 1'b0, 1'b0, '0);
    add_row(8'hc0, 1'b0, 1'b0, '0);
    add_row(8'ha8, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b1, 1'b1,
            make_summary(8'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'hc0a8_0101, 1'b1, 1'b0));
    // Message that stops right after a code: nothing kept, but truncated.
    add_row(dotp_pkg::OPT_ROUTER, 1'b1, 1'b1,
            make_summary(8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1));
    // Over-long NTP value, a zero-length DNS record, then a mask cut short.
    add_row(dotp_pkg::OPT_NTP, 1'b0, 1'b0, '0);
    add_row(8'd5, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b0, 1'b0, '0);
    add_row(8'h22, 1'b0, 1'b0, '0);
    add_row(8'h33, 1'b0, 1'b0, '0);
    add_row(8'h44, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, '0);
    add_row(dotp_pkg::OPT_DNS, 1'b0, 1'b0, '0);
    add_row(8'd0, 1'b0, 1'b0, '0);
    add_row(dotp_pkg::OPT_MASK, 1'b0, 1'b0, '0);
    add_row(8'd2, 1'b0, 1'b0, '0);
    add_row(8'hab, 1'b1, 1'b0, '0);
    // Words after the end code are ignored.
    add_row(dotp_pkg::OPT_END, 1'b0, 1'b0, '0);
    add_row(dotp_pkg::OPT_MSG_TYPE, 1'b1, 1'b1,
            make_summary(8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0));

    // Key settings for the random part: pad and end (never matched), two
    // codes that are captured anyway, one at random and the default.
    key_plan[0] = dotp_pkg::OPT_PAD;
    key_plan[1] = dotp_pkg::OPT_END;
    key_plan[2] = dotp_pkg::OPT_MASK;
    key_plan[3] = dotp_pkg::OPT_MSG_TYPE;
    key_plan[4] = 8'($urandom_range(255));
    key_plan[5] = dotp_pkg::SEARCH_KEY_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      send_byte(table_rows[i].data, table_rows[i].last, table_rows[i].typed,
                table_rows[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      set_search_key(key_plan[p]);
      // One whole setting runs back to back on both sides.
      calm = (p == 2);
      words_sent = 0;
      while (words_sent < WORDS_PER_KEY) begin
        build_message(search_key_copy);
        foreach (msg_bytes[i]) begin
          send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
        end
        words_sent += msg_bytes.size();
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[dhcp_option_tlv_parser.f]
+incdir+rtl
rtl/dotp_pkg.sv
rtl/dotp_front.sv
rtl/dotp_queue.sv
rtl/dotp_back.sv
rtl/dhcp_option_tlv_parser.sv
tb/dhcp_option_tlv_parser_test.sv
